// ----- hdl/sliding_window_median_macros.svh -----
// Assertion macros for the sliding window median block.
// Needs clk and rst_n in the scope of each use; no other dependencies.
`ifndef SLIDING_WINDOW_MEDIAN_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define SWM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SWM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SWM_ASSERT_IMP(lbl, ante, cons, msg)
`define SWM_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ----- hdl/swm_pkg.sv -----
// Shared constants and types for the sliding window median block.
// No dependencies; used by the interfaces, the sorting cell and the top level.
`default_nettype none

package swm_pkg;

  // default sizes
  localparam int SWM_WINDOW_MAX  = 64;
  localparam int SWM_SAMPLE_BITS = 32;
  localparam int SWM_CFG_W       = 7;

  // per-cell flags seen by both neighbors
  typedef struct packed {
    logic valid;  // cell holds a window sample
    logic lt_x;   // value below the sample leaving (or nothing leaves)
    logic gt_n;   // value above the sample arriving
  } swm_link_t;

  // broadcast control for the cell row
  typedef struct packed {
    logic en;      // a transaction updates the row this cycle
    logic remove;  // the oldest sample leaves the window
  } swm_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/swm_in_if.sv -----
// Input stream interface: valid/ready handshake with start flag and sample.
// Depends on swm_pkg for the default sample width.
`default_nettype none

interface swm_in_if #(
  parameter int SAMPLE_BITS = swm_pkg::SWM_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic                          start_sequence;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output start_sequence, output sample, input ready);
  modport sink   (input valid, input start_sequence, input sample, output ready);
endinterface

`default_nettype wire

// ----- hdl/swm_out_if.sv -----
// Result stream interface: valid/ready handshake carrying the median.
// Depends on swm_pkg for the default sample width.
`default_nettype none

interface swm_out_if #(
  parameter int SAMPLE_BITS = swm_pkg::SWM_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

`default_nettype wire

// ----- hdl/sliding_window_median.sv -----
// Sliding window lower-median filter, top level.
// Channels: in_stream carries start_sequence and a signed sample; out_stream
// carries the median. Both use valid/ready; a transaction moves on a rising
// edge with valid and ready high. cfg_we/cfg_wdata write the window length k
// (0 reads as 1, values above WINDOW_MAX saturate) and empty the window.
// Once k samples are held, each input transaction yields one median: the
// element of rank ceil(k/2). While the window fills there is no result.
// start_sequence empties the window before its own sample is taken.
// Throughput: one sample per cycle unless out_stream stalls, set by the row
// of sorting cells, which shifts every element by at most one slot per
// update, and by the ring memory read port that prefetches the sample about
// to leave. A median goes through the sorted row, then the output register.
// Stall: a result waits in the median stage while the output register is
// held; in_stream.ready drops only then, for as long as out_stream stalls.
// Reset (synchronous, rst_n low): window empty, k = 1, no result pending.
// The ring and sorted row need no clearing pass.
`default_nettype none

module sliding_window_median #(
  parameter int WINDOW_MAX  = swm_pkg::SWM_WINDOW_MAX,
  parameter int SAMPLE_BITS = swm_pkg::SWM_SAMPLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  swm_in_if.sink                             in_stream,
  swm_out_if.source                          out_stream,
  input  wire logic                          cfg_we,
  input  wire logic [swm_pkg::SWM_CFG_W-1:0] cfg_wdata
);

  import swm_pkg::*;

  `include "sliding_window_median_macros.svh"

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CMP_W = (CNT_W > SWM_CFG_W) ? CNT_W : SWM_CFG_W;

  // registers
  logic [SWM_CFG_W-1:0]          wlen_r;
  logic [CNT_W-1:0]              fill_r, fill_nxt;
  logic [IDX_W-1:0]              ptr_r, ptr_nxt;
  logic                          res_pend_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_median_r;

  logic [CMP_W-1:0]              wlen_ext;
  logic [CNT_W-1:0]              k_len;
  logic [IDX_W-1:0]              mid;
  logic                          accept;
  logic                          out_stall;
  logic                          start;
  logic [CNT_W-1:0]              fill_eff;
  logic [CNT_W-1:0]              fill_new;
  logic                          produce;
  logic [IDX_W-1:0]              waddr;
  logic [IDX_W-1:0]              ptr_adv;
  logic signed [SAMPLE_BITS-1:0] old_key;
  logic [SAMPLE_BITS-1:0]        old_raw;
  logic signed [SAMPLE_BITS-1:0] median;
  swm_ctrl_t                     ctrl;

  // active window length and median position
  assign wlen_ext = CMP_W'(wlen_r);
  always_comb begin
    if (wlen_ext == '0) begin
      k_len = CNT_W'(1);
    end else if (wlen_ext > CMP_W'(WINDOW_MAX)) begin
      k_len = CNT_W'(WINDOW_MAX);
    end else begin
      k_len = CNT_W'(wlen_ext);
    end
  end
  assign mid = IDX_W'((k_len - CNT_W'(1)) >> 1);

  // handshake
  assign out_stall       = out_valid_r && !out_stream.ready;
  assign in_stream.ready = !(res_pend_r && out_stall);
  assign accept          = in_stream.valid && in_stream.ready;
  assign start           = in_stream.start_sequence;

  // window bookkeeping for the incoming sample
  assign fill_eff = start ? '0 : fill_r;
  assign ctrl.en     = accept;
  assign ctrl.remove = fill_eff >= k_len;
  assign fill_new = ctrl.remove ? fill_eff : fill_eff + CNT_W'(1);
  assign produce  = fill_new == k_len;
  assign waddr    = start ? '0 : ptr_r;
  assign ptr_adv  = ((CNT_W'(waddr) + CNT_W'(1)) >= k_len) ? '0 :
                    IDX_W'(CNT_W'(waddr) + CNT_W'(1));

  always_comb begin
    fill_nxt = fill_r;
    ptr_nxt  = ptr_r;
    if (cfg_we) begin
      fill_nxt = '0;
      ptr_nxt  = '0;
    end else if (accept) begin
      fill_nxt = fill_new;
      ptr_nxt  = ptr_adv;
    end
  end

  // arrival-order ring; read data is the sample at the next write slot
  swm_ring #(
    .DEPTH  (WINDOW_MAX),
    .DATA_W (SAMPLE_BITS)
  ) u_ring (
    .clk     (clk),
    .we      (accept),
    .waddr   (waddr),
    .wdata   (in_stream.sample),
    .raddr   (ptr_nxt),
    .rdata_r (old_raw)
  );
  assign old_key = old_raw;

  // sorted row
  swm_link_t                     cell_link  [WINDOW_MAX];
  swm_link_t                     left_link  [WINDOW_MAX];
  swm_link_t                     right_link [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] cell_val   [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] left_val   [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] right_val  [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] cell_mid   [WINDOW_MAX];

  for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_link[g] = '{valid: 1'b0, lt_x: 1'b1, gt_n: 1'b0};
      assign left_val[g]  = '0;
    end else begin : g_left
      assign left_link[g] = cell_link[g-1];
      assign left_val[g]  = cell_val[g-1];
    end
    if (g == WINDOW_MAX - 1) begin : g_last
      assign right_link[g] = '{valid: 1'b0, lt_x: 1'b1, gt_n: 1'b0};
      assign right_val[g]  = '0;
    end else begin : g_right
      assign right_link[g] = cell_link[g+1];
      assign right_val[g]  = cell_val[g+1];
    end

    swm_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .WINDOW_MAX  (WINDOW_MAX),
      .IDX         (g)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .new_key    (in_stream.sample),
      .old_key    (old_key),
      .fill_eff   (fill_eff),
      .fill_new   (fill_new),
      .mid        (mid),
      .left_link  (left_link[g]),
      .left_val   (left_val[g]),
      .right_link (right_link[g]),
      .right_val  (right_val[g]),
      .link       (cell_link[g]),
      .val_r      (cell_val[g]),
      .mid_val    (cell_mid[g])
    );
  end

  // median tap: only the median cell drives nonzero
  always_comb begin
    median = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      median = median | cell_mid[i];
    end
  end

  // state, pending result and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r      <= SWM_CFG_W'(1);
      fill_r      <= '0;
      ptr_r       <= '0;
      res_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        wlen_r <= cfg_wdata;
      end
      fill_r <= fill_nxt;
      ptr_r  <= ptr_nxt;
      if (accept) begin
        res_pend_r <= produce;
      end else if (!out_stall) begin
        res_pend_r <= 1'b0;
      end
      if (!out_stall) begin
        out_valid_r <= res_pend_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_stall && res_pend_r) begin
      out_median_r <= median;
    end
  end

  assign out_stream.valid  = out_valid_r;
  assign out_stream.median = out_median_r;

  // checks
  `SWM_ASSERT_IMP(a_fill_bound, 1'b1, fill_r <= k_len, "fill count above window length")
  `SWM_ASSERT_NXT(a_result_full, accept && produce, fill_r == k_len, "result with window not full")
  `SWM_ASSERT_NXT(a_cfg_empties, cfg_we, (fill_r == '0) && (ptr_r == '0), "config did not empty window")
  `SWM_ASSERT_NXT(a_start_one, accept && start, fill_r == CNT_W'(1), "start did not restart window")

endmodule

`default_nettype wire

// ----- hdl/swm_ring.sv -----
// Arrival-order sample ring: one write port, one prefetching read port.
// Read data is registered; a write to the address being fetched is forwarded.
// Depends on swm_pkg for the default depth and data width.
`default_nettype none

module swm_ring #(
  parameter int DEPTH  = swm_pkg::SWM_WINDOW_MAX,
  parameter int DATA_W = swm_pkg::SWM_SAMPLE_BITS,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [IDX_W-1:0]  waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [IDX_W-1:0]  raddr,
  output logic      [DATA_W-1:0] rdata_r
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port with write-through for the same slot
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/swm_cell.sv -----
// One cell of the sorted row: holds one window sample in ascending position.
// Depends on swm_pkg; talks only to its two neighbors and the broadcast bus.
`default_nettype none

module swm_cell #(
  parameter int SAMPLE_BITS = swm_pkg::SWM_SAMPLE_BITS,
  parameter int WINDOW_MAX  = swm_pkg::SWM_WINDOW_MAX,
  parameter int IDX         = 0,
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1),
  localparam int IDX_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
  input  wire logic                          clk,
  input  wire swm_pkg::swm_ctrl_t            ctrl,
  input  wire logic signed [SAMPLE_BITS-1:0] new_key,
  input  wire logic signed [SAMPLE_BITS-1:0] old_key,
  input  wire logic        [CNT_W-1:0]       fill_eff,
  input  wire logic        [CNT_W-1:0]       fill_new,
  input  wire logic        [IDX_W-1:0]       mid,
  input  wire swm_pkg::swm_link_t            left_link,
  input  wire logic signed [SAMPLE_BITS-1:0] left_val,
  input  wire swm_pkg::swm_link_t            right_link,
  input  wire logic signed [SAMPLE_BITS-1:0] right_val,
  output swm_pkg::swm_link_t                 link,
  output logic signed [SAMPLE_BITS-1:0]      val_r,
  output logic signed [SAMPLE_BITS-1:0]      mid_val
);

  logic                          valid;
  logic                          live;
  logic                          take_left;
  logic                          take_self;
  logic                          take_right;
  logic signed [SAMPLE_BITS-1:0] val_nxt;

  // position flags; lt_x is monotone over the row, so it marks the leaving slot
  assign valid = CNT_W'(IDX) < fill_eff;
  assign live  = CNT_W'(IDX) < fill_new;
  assign link.valid = valid;
  assign link.lt_x  = !ctrl.remove || (val_r < old_key);
  assign link.gt_n  = val_r > new_key;

  // which element lands here: shifted right past the new sample, kept,
  // or shifted left over the removed one; the one free slot takes the new sample
  assign take_left  = left_link.valid && left_link.lt_x && left_link.gt_n;
  assign take_self  = valid && ((link.lt_x && !link.gt_n) ||
                                (!link.lt_x && !left_link.lt_x && link.gt_n));
  assign take_right = right_link.valid && !link.lt_x && !right_link.gt_n;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.en && live) begin
      if (take_left) begin
        val_nxt = left_val;
      end else if (take_self) begin
        val_nxt = val_r;
      end else if (take_right) begin
        val_nxt = right_val;
      end else begin
        val_nxt = new_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  // median tap, zero unless this is the median position
  assign mid_val = (IDX_W'(IDX) == mid) ? val_r : '0;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for sliding_window_median: directed table, then random phases over many window lengths.
// Each median is checked against an in-bench window predictor with random idling on both channels.
// Depends on swm_pkg, swm_in_if, swm_out_if and the sliding_window_median RTL.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swm_pkg::*;

  typedef logic signed [SWM_SAMPLE_BITS-1:0] sample_t;
  typedef logic [SWM_CFG_W-1:0] len_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_KNOWN, ROW_PRED} row_kind_t;

  // one line of the directed table
  typedef struct packed {
    row_kind_t kind;
    len_t      len;
    logic      start;
    sample_t   smp;
    sample_t   want;
  } row_t;

  // typed-in expectation travelling with an input transaction
  typedef struct packed {
    logic    known;
    sample_t val;
  } item_tag_t;

  localparam sample_t SMP_MIN      = {1'b1, {(SWM_SAMPLE_BITS-1){1'b0}}};
  localparam sample_t SMP_MAX      = {1'b0, {(SWM_SAMPLE_BITS-1){1'b1}}};
  localparam int      DRAIN_CYCLES = 8;
  localparam int      LIMIT        = 400000;
  localparam int      NUM_PHASES   = 12;
  localparam int      PHASE_ITEMS  = 140;
  localparam int      HOLD_PHASE   = 4;
  localparam int      HOLD_CYCLES  = 300;

  logic clk;
  logic rst_n;
  logic cfg_we;
  len_t cfg_wdata;

  swm_in_if  in_if ();
  swm_out_if out_if ();

  sliding_window_median dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_if),
    .out_stream (out_if),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // predictor state: window in arrival order and the same samples ascending
  sample_t   window_fifo[$];
  sample_t   window_sorted[$];
  int        win_len = 1;
  sample_t   median_q[$];
  item_tag_t item_tags[$];

  int errors      = 0;
  int samples_in  = 0;
  int medians_ok  = 0;
  int restarts    = 0;
  int len_writes  = 0;
  int cycles      = 0;
  int tx_max_gap  = 6;
  int rx_max_stall = 6;
  int hold_len    = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // advance the window by one sample; returns 1 when a median comes out
  function automatic logic slide_window(input logic st, input sample_t s, output sample_t med);
    sample_t oldest;
    int pos;
    med = '0;
    if (st) begin
      window_fifo.delete();
      window_sorted.delete();
    end
    if (window_fifo.size() >= win_len) begin
      oldest = window_fifo.pop_front();
      for (int i = 0; i < window_sorted.size(); i++) begin
        if (window_sorted[i] == oldest) begin
          window_sorted.delete(i);
          break;
        end
      end
    end
    window_fifo.push_back(s);
    pos = 0;
    while (pos < window_sorted.size() && window_sorted[pos] <= s) pos++;
    window_sorted.insert(pos, s);
    if (window_fifo.size() == win_len) begin
      med = window_sorted[(win_len - 1) / 2];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // check results, then track config writes and accepted samples
  always @(posedge clk) begin : monitor
    sample_t   want;
    sample_t   med;
    item_tag_t tg;
    logic      got;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (median_q.size() == 0) begin
          errors++;
          $display("%0t: median %0d with no expectation pending", $time, out_if.median);
        end else begin
          want = median_q.pop_front();
          if (out_if.median !== want) begin
            errors++;
            $display("%0t: median mismatch, expected %0d, got %0d", $time, want, out_if.median);
          end else begin
            medians_ok++;
          end
        end
      end
      if (cfg_we) begin
        win_len = (cfg_wdata == 0) ? 1 :
                  (cfg_wdata > SWM_WINDOW_MAX) ? SWM_WINDOW_MAX : int'(cfg_wdata);
        window_fifo.delete();
        window_sorted.delete();
      end
      if (in_if.valid && in_if.ready) begin
        tg = item_tags.pop_front();
        samples_in++;
        if (in_if.start_sequence) restarts++;
        got = slide_window(in_if.start_sequence, in_if.sample, med);
        if (tg.known) median_q.push_back(tg.val);
        else if (got) median_q.push_back(med);
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_side
    int stall;
    out_if.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_len != 0) begin
        stall = hold_len;
        hold_len = 0;
      end else begin
        stall = $urandom_range(0, rx_max_stall);
      end
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("%0t: timeout, %0d medians still pending", $time, median_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic row_t dir_row(input row_kind_t kind, input len_t len, input logic st,
                                   input sample_t smp, input sample_t want);
    row_t r;
    r.kind  = kind;
    r.len   = len;
    r.start = st;
    r.smp   = smp;
    r.want  = want;
    return r;
  endfunction

  function automatic sample_t pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0: return SMP_MIN;
      1: return SMP_MAX;
      2, 3: begin
        // narrow range, lots of equal samples
        v = $urandom_range(0, 16);
        return sample_t'(v - 8);
      end
      default: return sample_t'($urandom);
    endcase
  endfunction

  // offer one sample and hold it until the transaction completes
  task automatic send_item(input logic st, input sample_t smp, input logic known,
                           input sample_t want);
    int gap;
    item_tag_t tg;
    gap = $urandom_range(0, tx_max_gap);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tg.known = known;
    tg.val   = want;
    item_tags.push_back(tg);
    in_if.start_sequence <= st;
    in_if.sample         <= smp;
    in_if.valid          <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // stop offering, wait for every pending median, then let the pipe drain
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (median_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_len(input len_t v);
    settle();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    len_writes++;
  endtask

  initial begin : stimulus
    row_t dir_tab[$];
    int   phase_lens[6];
    int   len;
    logic st;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    in_if.valid          = 1'b0;
    in_if.start_sequence = 1'b0;
    in_if.sample         = '0;
    phase_lens = '{64, 127, 1, 0, 2, 65};

    // window length 1 after reset, then pairs, zero length and length 3
    dir_tab = '{
      dir_row(ROW_KNOWN, 0, 1'b0, SMP_MIN,       SMP_MIN),
      dir_row(ROW_KNOWN, 0, 1'b0, SMP_MAX,       SMP_MAX),
      dir_row(ROW_KNOWN, 0, 1'b0, 32'sd0,        32'sd0),
      dir_row(ROW_KNOWN, 0, 1'b0, -32'sd1,       -32'sd1),
      dir_row(ROW_KNOWN, 0, 1'b1, 32'sd5,        32'sd5),
      dir_row(ROW_CFG,   2, 1'b0, 32'sd0,        32'sd0),
      dir_row(ROW_PRED,  0, 1'b0, SMP_MAX,       32'sd0),
      dir_row(ROW_KNOWN, 0, 1'b0, SMP_MIN,       SMP_MIN),
      dir_row(ROW_KNOWN, 0, 1'b0, 32'sd3,        SMP_MIN),
      dir_row(ROW_PRED,  0, 1'b1, 32'sd10,       32'sd0),
      dir_row(ROW_KNOWN, 0, 1'b0, 32'sd20,       32'sd10),
      dir_row(ROW_KNOWN, 0, 1'b0, -32'sd7,       -32'sd7),
      dir_row(ROW_CFG,   0, 1'b0, 32'sd0,        32'sd0),
      dir_row(ROW_KNOWN, 0, 1'b0, 32'sd123,      32'sd123),
      dir_row(ROW_CFG,   3, 1'b0, 32'sd0,        32'sd0),
      dir_row(ROW_PRED,  0, 1'b0, 32'sd9,        32'sd0),
      dir_row(ROW_PRED,  0, 1'b0, -32'sd4,       32'sd0),
      dir_row(ROW_KNOWN, 0, 1'b0, 32'sd7,        32'sd7),
      dir_row(ROW_KNOWN, 0, 1'b0, 32'sd7,        32'sd7),
      dir_row(ROW_KNOWN, 0, 1'b0, SMP_MIN,       32'sd7),
      dir_row(ROW_PRED,  0, 1'b1, 32'sd1,        32'sd0),
      dir_row(ROW_PRED,  0, 1'b0, SMP_MAX,       32'sd0),
      dir_row(ROW_KNOWN, 0, 1'b0, SMP_MAX,       SMP_MAX)
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) write_len(dir_tab[i].len);
      else send_item(dir_tab[i].start, dir_tab[i].smp, dir_tab[i].kind == ROW_KNOWN,
                     dir_tab[i].want);
    end

    // random phases: fixed extremes first, then random lengths, mostly short
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 6) len = phase_lens[ph];
      else if ($urandom_range(0, 3) == 0) len = $urandom_range(0, 127);
      else len = $urandom_range(1, 16);
      write_len(len_t'(len));
      tx_max_gap   = ($urandom_range(0, 2) == 0) ? 0 : 6;
      rx_max_stall = ($urandom_range(0, 2) == 0) ? 0 : 6;
      if (ph == HOLD_PHASE) begin
        // back-to-back samples against a long output stall
        tx_max_gap = 0;
        hold_len   = HOLD_CYCLES;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        st = ($urandom_range(0, 49) == 0);
        send_item(st, pick_sample(), 1'b0, '0);
      end
    end

    settle();
    $display("Covered %0d samples and %0d checked medians, %0d restarts,", samples_in,
             medians_ok, restarts);
    $display("%0d window length writes, one long output stall; %0d errors", len_writes,
             errors);
    if (errors == 0 && median_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
